FILE: hdl/amhc_pkg.sv
// ----------------------------------------------------------------------------
// amhc_pkg
// Shared constants, command codes and helpers for the absolute maximum
// histogram collector and its quotient unit.
// ----------------------------------------------------------------------------
package amhc_pkg;

    localparam int BIN_COUNT_DEF    = 2048;
    localparam int TENSOR_COUNT_DEF = 16;

    localparam logic [1:0] CMD_UPD_MAX  = 2'd0;
    localparam logic [1:0] CMD_ADD_HIST = 2'd1;
    localparam logic [1:0] CMD_RD_BIN   = 2'd2;
    localparam logic [1:0] CMD_RD_MAX   = 2'd3;

    localparam logic       KIND_BIN = 1'b0;
    localparam logic       KIND_MAX = 1'b1;

    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Request to the quotient unit: start pulse, magnitude and divisor
    typedef struct packed {
        logic        start;
        logic [30:0] mag;
        logic [30:0] mx;
    } div_req_t;

    // Magnitude of a signed Q16.16 sample, most negative value saturated
    function automatic logic [30:0] magnitude_of(input logic [31:0] v);
        logic [31:0] m;
        m = ~v + 32'd1;
        if (!v[31]) begin
            return v[30:0];
        end
        if (m[31]) begin
            return MAG_MAX;
        end
        return m[30:0];
    endfunction

endpackage

FILE: hdl/amhc_div.sv
// ----------------------------------------------------------------------------
// amhc_div
// Bin quotient unit: floor(mag * BIN_COUNT / mx) for mag below mx, a
// multiply step and then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amhc_div
    import amhc_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF,
    parameter int QW        = $clog2(BIN_COUNT)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  div_req_t      req,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int NW = 31 + QW;
    localparam int CW = $clog2(QW + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [30:0]   mag_reg, mag_next;
    logic [30:0]   mx_reg, mx_next;
    logic [30:0]   rem_reg, rem_next;
    logic [QW-1:0] shf_reg, shf_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic [NW-1:0] num;
    logic [31:0]   trial;
    logic          ge;

    // Scaled numerator and one restoring step
    assign num   = NW'(mag_reg) * NW'(BIN_COUNT);
    assign trial = {rem_reg, shf_reg[QW-1]};
    assign ge    = trial >= {1'b0, mx_reg};

    // Sequence multiply, then QW quotient steps
    always_comb begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        mx_next    = mx_reg;
        rem_next   = rem_reg;
        shf_next   = shf_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (req.start) begin
                    mag_next   = req.mag;
                    mx_next    = req.mx;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL: begin
                rem_next   = num[NW-1:QW];
                shf_next   = num[QW-1:0];
                cnt_next   = '0;
                phase_next = PH_RUN;
            end
            PH_RUN: begin
                rem_next = ge ? 31'(trial - {1'b0, mx_reg}) : trial[30:0];
                shf_next = QW'({shf_reg, 1'b0});
                q_next   = QW'({q_reg, ge});
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(QW - 1)) begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        mag_reg <= mag_next;
        mx_reg  <= mx_next;
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

    // Remainder stays below the divisor while running
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RUN) |-> (rem_reg < mx_reg))
        else $error("quotient remainder not below divisor");

    // Done follows only a run step
    a_done_src: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(phase_reg) == PH_RUN)
        else $error("done without a quotient step");

    // A start in the idle phase leads to the multiply phase
    a_start_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE && req.start) |=> (phase_reg == PH_MUL))
        else $error("start not taken");

endmodule

FILE: hdl/abs_max_histogram_collector.sv
// ----------------------------------------------------------------------------
// abs_max_histogram_collector
// Per-tensor running absolute maximum and saturating magnitude histogram
// for quantization calibration, histogram held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | dir | tvalid/tready | tuser          | tdata
//  s_      | in  | handshake     | [1:0] cmd      | tensor_index, sample, bin
//  m_      | out | handshake     | [0] read_kind  | bin_count, max_magnitude
//
//  Update max: written at accept. Read max: through S_RES to the output register.
//  Read bin: memory read at accept, then S_RD and S_RES. Add to histogram:
//  S_DIV (quotient unit, one bit per cycle), then a memory read-modify-write
//  in S_RRD and S_RWR; S_DIV is skipped when the bin is clamped.
//  After reset a clearing pass writes zero to all TENSOR_COUNT*BIN_COUNT
//  entries, one per cycle; no beat is accepted until it ends.
//  A result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module abs_max_histogram_collector
    import amhc_pkg::*;
#(
    parameter int BIN_COUNT    = BIN_COUNT_DEF,
    parameter int TENSOR_COUNT = TENSOR_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tensor_index[3:0], sample_value[35:4], bin_index[46:36]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // bin_count[31:0], max_magnitude[62:32]
    output logic        m_tuser    // read_kind[0]
);

    localparam int QW    = $clog2(BIN_COUNT);
    localparam int TW    = (TENSOR_COUNT > 1) ? $clog2(TENSOR_COUNT) : 1;
    localparam int DEPTH = TENSOR_COUNT * BIN_COUNT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RRD   = 3'd3;
    localparam logic [2:0] S_RWR   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [3:0]    t_reg, t_next;
    logic [QW-1:0] idx_reg, idx_next;
    logic          ok_reg, ok_next;
    logic          kind_reg, kind_next;
    logic [31:0]   cnt_res_reg, cnt_res_next;
    logic [30:0]   max_res_reg, max_res_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_kind_reg, m_kind_next;
    logic [31:0]   m_cnt_reg, m_cnt_next;
    logic [30:0]   m_max_reg, m_max_next;

    logic [30:0]   max_reg [TENSOR_COUNT];
    logic [31:0]   hist_mem [DEPTH];
    logic [31:0]   rd_data_reg;

    logic [1:0]    cmd;
    logic [3:0]    ti;
    logic [31:0]   sample;
    logic [10:0]   bi;
    logic          acc;
    logic          t_ok;
    logic [30:0]   mag;
    logic [30:0]   mx_cur;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    div_req_t      div_req;
    logic          div_done;
    logic [QW-1:0] div_quot;

    // Unpack the input beat
    assign cmd    = s_tuser;
    assign ti     = s_tdata[3:0];
    assign sample = s_tdata[35:4];
    assign bi     = s_tdata[46:36];

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign t_ok     = 32'(ti) < TENSOR_COUNT;
    assign mag      = magnitude_of(sample);
    assign mx_cur   = t_ok ? max_reg[TW'(ti)] : '0;

    // Start the quotient unit only for an in-range bin
    assign div_req.start = acc && (cmd == CMD_ADD_HIST) && t_ok &&
                           (mx_cur != '0) && (mag < mx_cur);
    assign div_req.mag   = mag;
    assign div_req.mx    = mx_cur;

    amhc_div #(
        .BIN_COUNT (BIN_COUNT),
        .QW        (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Pick the memory read address: bin read at accept, histogram update later
    always_comb begin
        if (state_reg == S_IDLE) begin
            rd_addr = AW'(AW'(ti) * AW'(BIN_COUNT) + AW'(bi));
        end else begin
            rd_addr = AW'(AW'(t_reg) * AW'(BIN_COUNT) + AW'(idx_reg));
        end
    end

    // Write zero during the clearing pass, the bumped count otherwise
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = '0;
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end else if (state_reg == S_RWR) begin
            wr_en   = 1'b1;
            wr_data = (rd_data_reg == CNT_MAX) ? rd_data_reg : rd_data_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // Fold a sample into the tensor maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TENSOR_COUNT; i++) begin
                max_reg[i] <= '0;
            end
        end else if (acc && (cmd == CMD_UPD_MAX) && t_ok && (mag > mx_cur)) begin
            max_reg[TW'(ti)] <= mag;
        end
    end

    // Sequence commands and hold results for the output register
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        t_next        = t_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        kind_next     = kind_reg;
        cnt_res_next  = cnt_res_reg;
        max_res_next  = max_res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_cnt_next    = m_cnt_reg;
        m_max_next    = m_max_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    t_next = ti;
                    unique case (cmd)
                        CMD_UPD_MAX: begin
                            state_next = S_IDLE;
                        end
                        CMD_ADD_HIST: begin
                            idx_next = QW'(BIN_COUNT - 1);
                            if (!t_ok) begin
                                state_next = S_IDLE;
                            end else if (div_req.start) begin
                                state_next = S_DIV;
                            end else begin
                                state_next = S_RRD;
                            end
                        end
                        CMD_RD_BIN: begin
                            ok_next    = t_ok && (32'(bi) < BIN_COUNT);
                            state_next = S_RD;
                        end
                        CMD_RD_MAX: begin
                            kind_next    = KIND_MAX;
                            cnt_res_next = '0;
                            max_res_next = mx_cur;
                            state_next   = S_RES;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    idx_next   = div_quot;
                    state_next = S_RRD;
                end
            end
            S_RRD: begin
                state_next = S_RWR;
            end
            S_RWR: begin
                state_next = S_IDLE;
            end
            S_RD: begin
                kind_next    = KIND_BIN;
                cnt_res_next = ok_reg ? rd_data_reg : '0;
                max_res_next = '0;
                state_next   = S_RES;
            end
            S_RES: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = kind_reg;
                    m_cnt_next    = cnt_res_reg;
                    m_max_next    = max_res_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        t_reg       <= t_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        kind_reg    <= kind_next;
        cnt_res_reg <= cnt_res_next;
        max_res_reg <= max_res_next;
        m_kind_reg  <= m_kind_next;
        m_cnt_reg   <= m_cnt_next;
        m_max_reg   <= m_max_next;
    end

    // Pack the output beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_max_reg, m_cnt_reg};

    // Write-back follows its own read
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RWR) |-> $past(state_reg) == S_RRD)
        else $error("histogram write-back without read");

    // A maximum result carries no count, a bin result no maximum
    a_res_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_kind_reg == KIND_MAX) ? (m_cnt_reg == '0) : (m_max_reg == '0))
        else $error("result carries the other kind's field");

    // A maximum update never lowers the stored value
    a_max_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && cmd == CMD_UPD_MAX && t_ok) |=> (max_reg[TW'($past(ti))] >= $past(mx_cur)))
        else $error("tensor maximum decreased");

    // The quotient unit reports only while waiting for it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("quotient done outside wait");

endmodule
